### hdl/mwmd_pkg.sv
// Package for the mecanum wheel mixer: field widths, mode and register codes,
// fixed-point constants and the types shared by the pipeline modules.
// No dependencies.
`timescale 1ns / 1ps

package mwmd_pkg;

  // Field widths.
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimW     = 15;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned Lanes    = 4;
  localparam int unsigned FracW    = 12;

  // APB register port.
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // Internal widths. Wheels are first formed at 5 * 2^12 times their value.
  // The linear mix -vx - vy reaches +2^SpeedW, so it needs two extra bits.
  localparam int unsigned LinW     = SpeedW + 2;
  localparam int unsigned LinTermW = SpeedW + 9;
  localparam int unsigned ProdW    = GainW + SpeedW;
  localparam int unsigned AccW     =
      ((LinTermW + FracW > ProdW + 3) ? LinTermW + FracW : ProdW + 3) + 1;
  localparam int unsigned TW       = AccW - FracW;

  // Division by five through a reciprocal, followed by one correction step.
  localparam int unsigned DenScale = 5;
  localparam int unsigned RecipSh  = TW + 3;
  localparam int unsigned RecipW   = RecipSh - 2;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipSh) / 64'd5);
  localparam int unsigned PW       = TW + RecipW;
  localparam int unsigned MagW     = PW - RecipSh;

  // Half of the Q3.12 scale denominator, for round to nearest.
  localparam int unsigned RoundHalf = (DenScale << FracW) / 2;

  // Desaturation divider.
  localparam int unsigned NumW     = MagW + LimW;
  localparam int unsigned QW       = LimW;
  localparam int unsigned QIdxW    = $clog2(QW);
  localparam int unsigned DivStages = QW;

  // Pipeline depth: seven arithmetic stages, the divider, the output register.
  localparam int unsigned PreStages = 7;
  localparam int unsigned NumStages = PreStages + DivStages + 1;

  // Saturation bounds on the magnitude.
  localparam logic [MagW-1:0] SatPosMag = MagW'((64'd1 << (SpeedW - 1)) - 64'd1);
  localparam logic [MagW-1:0] SatNegMag = MagW'(64'd1 << (SpeedW - 1));

  typedef enum logic [ModeW-1:0] {
    ModeZeroForce    = 3'd0,
    ModeNoMove       = 3'd1,
    ModeFollowGimbal = 3'd2,
    ModeSpin         = 3'd3,
    ModeNoFollow     = 3'd4
  } drive_mode_e;

  typedef enum logic [ApbAddrW-3:0] {
    RegFrontGain = 2'd0,
    RegRearGain  = 2'd1,
    RegMaxSpeed  = 2'd2
  } cfg_reg_e;

  localparam logic signed [GainW-1:0] FrontGainRst = -16'sd737;
  localparam logic signed [GainW-1:0] RearGainRst  = -16'sd901;
  localparam logic [LimW-1:0]         MaxSpeedRst  = 15'd16384;

  typedef struct packed {
    logic signed [GainW-1:0] front_gain;
    logic signed [GainW-1:0] rear_gain;
    logic [LimW-1:0]         max_speed;
  } cfg_t;

  // One row of the desaturation divider pipeline.
  typedef struct packed {
    logic [Lanes-1:0][NumW-1:0] rem;
    logic [Lanes-1:0][QW-1:0]   quo;
    logic [MagW-1:0]            den;
    logic [Lanes-1:0]           neg;
    logic [Lanes-1:0][MagW-1:0] mag;
    logic                       limited;
  } div_bus_t;

endpackage

### hdl/mwmd_cmd_if.sv
// Command channel of the mecanum wheel mixer: valid/ready plus one command.
// Depends on mwmd_pkg.
`timescale 1ns / 1ps

interface mwmd_cmd_if import mwmd_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] forward_speed;
  logic signed [SpeedW-1:0] sideways_speed;
  logic signed [SpeedW-1:0] turn_rate;
  logic [ModeW-1:0]         drive_mode;
  logic                     slow_mode;
  logic signed [SpeedW-1:0] yaw_rate_offset;

  modport source (
    output valid, forward_speed, sideways_speed, turn_rate, drive_mode, slow_mode,
           yaw_rate_offset,
    input  ready
  );

  modport sink (
    input  valid, forward_speed, sideways_speed, turn_rate, drive_mode, slow_mode,
           yaw_rate_offset,
    output ready
  );

endinterface

### hdl/mwmd_wheel_if.sv
// Result channel of the mecanum wheel mixer: valid/ready plus four wheel speeds.
// Depends on mwmd_pkg.
`timescale 1ns / 1ps

interface mwmd_wheel_if import mwmd_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] wheel_a_speed;
  logic signed [SpeedW-1:0] wheel_b_speed;
  logic signed [SpeedW-1:0] wheel_c_speed;
  logic signed [SpeedW-1:0] wheel_d_speed;
  logic                     was_limited;

  modport source (
    output valid, wheel_a_speed, wheel_b_speed, wheel_c_speed, wheel_d_speed, was_limited,
    input  ready
  );

  modport sink (
    input  valid, wheel_a_speed, wheel_b_speed, wheel_c_speed, wheel_d_speed, was_limited,
    output ready
  );

endinterface

### hdl/mwmd_apb_regs.sv
// APB configuration registers of the mecanum wheel mixer (spin gains, speed limit).
// Depends on mwmd_pkg.
`timescale 1ns / 1ps

module mwmd_apb_regs import mwmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic signed [GainW-1:0] front_gain_q, front_gain_d;
  logic signed [GainW-1:0] rear_gain_q, rear_gain_d;
  logic [LimW-1:0]         max_speed_q, max_speed_d;
  logic                    wr_en;
  cfg_reg_e                reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = cfg_reg_e'(paddr[ApbAddrW-1:2]);

  // Register write decode.
  always_comb begin
    front_gain_d = front_gain_q;
    rear_gain_d  = rear_gain_q;
    max_speed_d  = max_speed_q;
    if (wr_en) begin
      case (reg_idx)
        RegFrontGain: front_gain_d = pwdata[GainW-1:0];
        RegRearGain:  rear_gain_d  = pwdata[GainW-1:0];
        RegMaxSpeed:  max_speed_d  = pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_gain_q <= FrontGainRst;
      rear_gain_q  <= RearGainRst;
      max_speed_q  <= MaxSpeedRst;
    end else begin
      front_gain_q <= front_gain_d;
      rear_gain_q  <= rear_gain_d;
      max_speed_q  <= max_speed_d;
    end
  end

  // Read mux; gains read back sign extended.
  always_comb begin
    case (reg_idx)
      RegFrontGain: prdata = ApbDataW'(front_gain_q);
      RegRearGain:  prdata = ApbDataW'(rear_gain_q);
      RegMaxSpeed:  prdata = ApbDataW'(max_speed_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = '{front_gain: front_gain_q, rear_gain: rear_gain_q, max_speed: max_speed_q};

endmodule

### hdl/mwmd_div_pipe.sv
// Pipelined restoring divider for the wheel desaturation: one quotient bit per
// stage for all four wheels against a shared divisor. Depends on mwmd_pkg.
`timescale 1ns / 1ps

module mwmd_div_pipe import mwmd_pkg::*; (
  input  logic                 clk_i,
  input  logic [DivStages-1:0] en_i,
  input  div_bus_t             din_i,
  output div_bus_t             dout_o
);

  // One restoring step: try to subtract the divisor shifted to this bit.
  function automatic div_bus_t div_step(div_bus_t b, logic [QIdxW-1:0] bitpos);
    div_bus_t        r;
    logic [NumW-1:0] sub;
    r   = b;
    sub = NumW'(b.den) << bitpos;
    for (int l = 0; l < Lanes; l++) begin
      if (b.rem[l] >= sub) begin
        r.rem[l]         = b.rem[l] - sub;
        r.quo[l][bitpos] = 1'b1;
      end
    end
    return r;
  endfunction

  div_bus_t stage_q [DivStages];
  div_bus_t stage_d [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    // Stage k resolves quotient bit QW-1-k.
    if (k == 0) begin : g_first
      assign stage_d[k] = div_step(din_i, QIdxW'(QW - 1));
    end else begin : g_rest
      assign stage_d[k] = div_step(stage_q[k-1], QIdxW'(QW - 1 - k));
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign dout_o = stage_q[DivStages-1];

endmodule

### hdl/mecanum_wheel_mixer_desaturate_unit.sv
// Top level of the mecanum wheel mixer with desaturation.
// Depends on mwmd_pkg, mwmd_cmd_if, mwmd_wheel_if, mwmd_apb_regs and mwmd_div_pipe.
`timescale 1ns / 1ps

// Usage:
// A chassis command request (vx, vy, wz, drive mode, slow flag, yaw-rate offset)
// enters on cmd_i with valid/ready; one result request with four wheel setpoints
// and the was_limited flag leaves on wheel_o. All speeds are signed Q3.12.
// The spin gains and the wheel speed limit sit in APB registers at byte
// addresses 0, 4 and 8; write them only while no command is in flight.
// An accepted command passes seven arithmetic stages (mix, accumulate,
// round, reciprocal multiply, correction, peak search, scale numerator),
// fifteen stages of the restoring divider that produces one quotient bit
// per stage, and the output register. Every stage carries a valid bit.
// Throughput is one command per cycle while the receiver takes results.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling any empty slot, so ready on cmd_i drops only
// once all 23 stages hold a command.
// Reset clears the valid bits and loads the register defaults.

module mecanum_wheel_mixer_desaturate_unit import mwmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  mwmd_cmd_if.sink            cmd_i,
  mwmd_wheel_if.source        wheel_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned StgMix   = 0;
  localparam int unsigned StgAcc   = 1;
  localparam int unsigned StgAbs   = 2;
  localparam int unsigned StgMul   = 3;
  localparam int unsigned StgQuo   = 4;
  localparam int unsigned StgMax   = 5;
  localparam int unsigned StgNum   = 6;
  localparam int unsigned DivFirst = PreStages;
  localparam int unsigned OutStage = NumStages - 1;

  cfg_t cfg;

  mwmd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NumStages-1:0] valid_q, valid_d, stage_en, valid_in;

  assign stage_en[NumStages-1] = ~valid_q[NumStages-1] | wheel_o.ready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign stage_en[k] = ~valid_q[k] | stage_en[k+1];
  end

  assign valid_in = {valid_q[NumStages-2:0], cmd_i.valid};
  assign valid_d  = (stage_en & valid_in) | (~stage_en & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign cmd_i.ready = stage_en[StgMix];

  // Stage 0: mode decode, linear and offset terms, gain products.
  logic                       is_spin, is_nofollow, lin_x2, sub_off;
  logic signed [LinW-1:0]     vx, vy;
  logic signed [LinW-1:0]     lin [Lanes];
  logic signed [LinTermW-1:0] lin_ext [Lanes];
  logic signed [LinTermW-1:0] off_ext, off200;
  logic signed [LinTermW-1:0] s0_lin_d [Lanes];
  logic signed [LinTermW-1:0] s0_lin_q [Lanes];
  logic signed [ProdW-1:0]    s0_pf_d, s0_pr_d, s0_pf_q, s0_pr_q;
  logic                       s0_rot4_d, s0_rot4_q, s0_zf_d, s0_zf_q;

  always_comb begin
    is_spin     = cmd_i.drive_mode == ModeSpin;
    is_nofollow = cmd_i.drive_mode == ModeNoFollow;
    lin_x2      = !is_spin && cmd_i.slow_mode;
    s0_rot4_d   = lin_x2 && is_nofollow;
    sub_off     = !is_spin && !is_nofollow;
    s0_zf_d     = cmd_i.drive_mode == ModeZeroForce;
    vx = LinW'(cmd_i.forward_speed);
    vy = LinW'(cmd_i.sideways_speed);
    lin[0] = -vx - vy;
    lin[1] =  vx - vy;
    lin[2] =  vx + vy;
    lin[3] = -vx + vy;
    // 200 * offset, that is 40 * offset at the common scale of five.
    off_ext = LinTermW'(cmd_i.yaw_rate_offset);
    off200  = (off_ext <<< 7) + (off_ext <<< 6) + (off_ext <<< 3);
    for (int l = 0; l < Lanes; l++) begin
      lin_ext[l]  = LinTermW'(lin[l]);
      s0_lin_d[l] = (lin_x2 ? (lin_ext[l] <<< 1) : ((lin_ext[l] <<< 2) + lin_ext[l]))
                  - (sub_off ? off200 : LinTermW'(0));
    end
    s0_pf_d = ProdW'(cfg.front_gain) * ProdW'(cmd_i.turn_rate);
    s0_pr_d = ProdW'(cfg.rear_gain) * ProdW'(cmd_i.turn_rate);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[StgMix]) begin
      s0_lin_q  <= s0_lin_d;
      s0_pf_q   <= s0_pf_d;
      s0_pr_q   <= s0_pr_d;
      s0_rot4_q <= s0_rot4_d;
      s0_zf_q   <= s0_zf_d;
    end
  end

  // Stage 1: full accumulator, linear part at 2^12 plus four or five times the product.
  logic signed [AccW-1:0] s1_rot [Lanes];
  logic signed [AccW-1:0] s1_acc_d [Lanes];
  logic signed [AccW-1:0] s1_acc_q [Lanes];
  logic                   s1_zf_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      s1_rot[l]   = (l < 2) ? AccW'(s0_pf_q) : AccW'(s0_pr_q);
      s1_acc_d[l] = (AccW'(s0_lin_q[l]) <<< FracW) + (s1_rot[l] <<< 2)
                  + (s0_rot4_q ? AccW'(0) : s1_rot[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[StgAcc]) begin
      s1_acc_q <= s1_acc_d;
      s1_zf_q  <= s0_zf_q;
    end
  end

  // Stage 2: magnitude plus half the denominator, then the power-of-two part of it.
  logic [AccW-1:0]  s2_abs [Lanes];
  logic [AccW-1:0]  s2_sum [Lanes];
  logic [TW-1:0]    s2_t_d [Lanes];
  logic [TW-1:0]    s2_t_q [Lanes];
  logic [Lanes-1:0] s2_neg_d, s2_neg_q;
  logic             s2_zf_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      s2_neg_d[l] = s1_acc_q[l][AccW-1];
      s2_abs[l]   = s2_neg_d[l] ? AccW'(-s1_acc_q[l]) : AccW'(s1_acc_q[l]);
      s2_sum[l]   = s2_abs[l] + AccW'(RoundHalf);
      s2_t_d[l]   = s2_sum[l][AccW-1:FracW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[StgAbs]) begin
      s2_t_q   <= s2_t_d;
      s2_neg_q <= s2_neg_d;
      s2_zf_q  <= s1_zf_q;
    end
  end

  // Stage 3: multiply by the reciprocal of five.
  logic [PW-1:0]    s3_prod_d [Lanes];
  logic [PW-1:0]    s3_prod_q [Lanes];
  logic [TW-1:0]    s3_t_q [Lanes];
  logic [Lanes-1:0] s3_neg_q;
  logic             s3_zf_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      s3_prod_d[l] = PW'(s2_t_q[l]) * PW'(Recip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[StgMul]) begin
      s3_prod_q <= s3_prod_d;
      s3_t_q    <= s2_t_q;
      s3_neg_q  <= s2_neg_q;
      s3_zf_q   <= s2_zf_q;
    end
  end

  // Stage 4: the estimate is low by at most one; fix it from the remainder.
  logic [MagW-1:0]  s4_est [Lanes];
  logic [TW-1:0]    s4_rem [Lanes];
  logic [MagW-1:0]  s4_mag_d [Lanes];
  logic [MagW-1:0]  s4_mag_q [Lanes];
  logic [Lanes-1:0] s4_neg_q;
  logic             s4_zf_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      s4_est[l]   = s3_prod_q[l][RecipSh +: MagW];
      s4_rem[l]   = s3_t_q[l] - ((TW'(s4_est[l]) << 2) + TW'(s4_est[l]));
      s4_mag_d[l] = s4_est[l] + MagW'(s4_rem[l] >= TW'(DenScale));
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[StgQuo]) begin
      s4_mag_q <= s4_mag_d;
      s4_neg_q <= s3_neg_q;
      s4_zf_q  <= s3_zf_q;
    end
  end

  // Stage 5: largest wheel magnitude and the limit check.
  logic [MagW-1:0]  s5_m01, s5_m23, s5_max_d, s5_max_q;
  logic             s5_lim_d, s5_lim_q;
  logic [MagW-1:0]  s5_mag_q [Lanes];
  logic [Lanes-1:0] s5_neg_q;

  always_comb begin
    s5_m01   = (s4_mag_q[0] > s4_mag_q[1]) ? s4_mag_q[0] : s4_mag_q[1];
    s5_m23   = (s4_mag_q[2] > s4_mag_q[3]) ? s4_mag_q[2] : s4_mag_q[3];
    s5_max_d = (s5_m01 > s5_m23) ? s5_m01 : s5_m23;
    s5_lim_d = !s4_zf_q && (s5_max_d > MagW'(cfg.max_speed));
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[StgMax]) begin
      s5_max_q <= s5_max_d;
      s5_lim_q <= s5_lim_d;
      s5_mag_q <= s4_mag_q;
      s5_neg_q <= s4_neg_q;
    end
  end

  // Stage 6: rounded scale numerator |w| * limit + max / 2 for the divider.
  div_bus_t div_in_d, div_in_q, div_out;

  always_comb begin
    div_in_d = '0;
    for (int l = 0; l < Lanes; l++) begin
      div_in_d.rem[l] = NumW'(s5_mag_q[l]) * NumW'(cfg.max_speed) + NumW'(s5_max_q >> 1);
      div_in_d.mag[l] = s5_mag_q[l];
    end
    div_in_d.den     = s5_max_q;
    div_in_d.neg     = s5_neg_q;
    div_in_d.limited = s5_lim_q;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[StgNum]) begin
      div_in_q <= div_in_d;
    end
  end

  mwmd_div_pipe u_div (
    .clk_i  (clk_i),
    .en_i   (stage_en[DivFirst +: DivStages]),
    .din_i  (div_in_q),
    .dout_o (div_out)
  );

  // Output stage: pick the scaled or raw magnitude, restore the sign, saturate.
  logic [MagW-1:0]          out_mag [Lanes];
  logic signed [SpeedW-1:0] out_d [Lanes];
  logic signed [SpeedW-1:0] out_q [Lanes];
  logic                     limited_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      out_mag[l] = div_out.limited ? MagW'(div_out.quo[l]) : div_out.mag[l];
      if (!div_out.neg[l]) begin
        out_d[l] = (out_mag[l] > SatPosMag) ? SpeedW'(SatPosMag) : SpeedW'(out_mag[l]);
      end else begin
        out_d[l] = (out_mag[l] > SatNegMag) ? SpeedW'(SatNegMag) : -SpeedW'(out_mag[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[OutStage]) begin
      out_q     <= out_d;
      limited_q <= div_out.limited;
    end
  end

  assign wheel_o.valid         = valid_q[OutStage];
  assign wheel_o.wheel_a_speed = out_q[0];
  assign wheel_o.wheel_b_speed = out_q[1];
  assign wheel_o.wheel_c_speed = out_q[2];
  assign wheel_o.wheel_d_speed = out_q[3];
  assign wheel_o.was_limited   = limited_q;

  // An accepted command occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> valid_q[StgMix])
    else $error("accepted command missing from the first stage");

  // Any empty stage lets a new command in.
  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> cmd_i.ready)
    else $error("input stalled while the pipeline has an empty stage");

  // A full pipeline behind a stalled receiver takes nothing.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !wheel_o.ready |-> !cmd_i.ready)
    else $error("input accepted with a full pipeline and a stalled output");

  // Scaling is only requested with a nonzero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[StgNum] && div_in_q.limited |-> div_in_q.den != '0)
    else $error("desaturation requested with a zero peak magnitude");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the mecanum wheel mixer with desaturation.
// Drives chassis command requests and APB register writes, predicts the four
// wheel setpoints, and checks every result request. Depends on mwmd_pkg and both channel interfaces.
`timescale 1ns / 1ps

module tb_top;
  import mwmd_pkg::*;

  // Fixed-point scales used by the wheel predictor.
  localparam longint QScale    = longint'(1) << FracW;
  localparam longint WheelDen  = DenScale * QScale;
  localparam longint SatHi     = (longint'(1) << (SpeedW - 1)) - 1;
  localparam longint SatLo     = -SatHi - 1;
  localparam int     CycleLimit = 200000;

  typedef struct packed {
    logic signed [SpeedW-1:0] fwd;
    logic signed [SpeedW-1:0] side;
    logic signed [SpeedW-1:0] turn;
    logic [ModeW-1:0]         mode;
    logic                     slow;
    logic signed [SpeedW-1:0] ofs;
  } chassis_cmd_t;

  typedef struct packed {
    logic [Lanes-1:0][SpeedW-1:0] wheel;
    logic                         limited;
  } wheel_set_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  logic sink_ready = 1'b0;

  mwmd_cmd_if   cmd_bus ();
  mwmd_wheel_if wheel_bus ();

  assign wheel_bus.ready = sink_ready;

  cfg_t       cfg_now;
  wheel_set_t expected_wheels[$];
  wheel_set_t want;
  int         err_count   = 0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  bit         idle_on     = 1'b1;

  mecanum_wheel_mixer_desaturate_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .wheel_o (wheel_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Round to nearest with ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Computes the four wheel setpoints and the limit flag for one command.
  function automatic wheel_set_t predict_wheels(chassis_cmd_t c, cfg_t k);
    wheel_set_t r;
    longint vx, vy, wz, ofs, gain, acc, mag, peak, lim, v;
    longint lin_mul, rot_mul, ofs_mul;
    longint lin [Lanes];
    longint raw [Lanes];
    vx = c.fwd;
    vy = c.side;
    wz = c.turn;
    ofs = c.ofs;
    lim = k.max_speed;
    lin_mul = DenScale;
    rot_mul = DenScale;
    ofs_mul = DenScale;
    // Spin ignores the slow flag and the offset; no-follow-yaw drops the offset.
    if (c.mode == ModeSpin) begin
      ofs_mul = 0;
    end else begin
      if (c.slow) begin
        lin_mul = 2;
        if (c.mode == ModeNoFollow) rot_mul = 4;
      end
      if (c.mode == ModeNoFollow) ofs_mul = 0;
    end
    lin[0] = -vx - vy;
    lin[1] = vx - vy;
    lin[2] = vx + vy;
    lin[3] = -vx + vy;
    peak = 0;
    for (int i = 0; i < Lanes; i++) begin
      if (i < 2) gain = k.front_gain;
      else gain = k.rear_gain;
      acc = lin_mul * lin[i] * QScale + rot_mul * gain * wz - ofs_mul * 40 * ofs * QScale;
      raw[i] = round_div(acc, WheelDen);
      mag = (raw[i] < 0) ? -raw[i] : raw[i];
      if (mag > peak) peak = mag;
    end
    // Zero force passes the raw wheels through without the limit check.
    r.limited = (c.mode != ModeZeroForce) && (peak > lim);
    for (int i = 0; i < Lanes; i++) begin
      v = r.limited ? round_div(raw[i] * lim, peak) : raw[i];
      if (v > SatHi) v = SatHi;
      if (v < SatLo) v = SatLo;
      r.wheel[i] = v[SpeedW-1:0];
    end
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Result monitor, receiver stalls and the run watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      if (rst_ni && wheel_bus.valid && wheel_bus.ready) begin
        if (expected_wheels.size() == 0) begin
          $error("unexpected result request");
          err_count++;
        end else begin
          want = expected_wheels.pop_front();
          check_field("wheel_a_speed", $signed(want.wheel[0]), wheel_bus.wheel_a_speed);
          check_field("wheel_b_speed", $signed(want.wheel[1]), wheel_bus.wheel_b_speed);
          check_field("wheel_c_speed", $signed(want.wheel[2]), wheel_bus.wheel_c_speed);
          check_field("wheel_d_speed", $signed(want.wheel[3]), wheel_bus.wheel_d_speed);
          check_field("was_limited", want.limited, wheel_bus.was_limited);
        end
      end
      // Receiver stalls start at random, and only while idling is enabled.
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
      sink_ready <= (stall_left == 0);
    end
  end

  function automatic chassis_cmd_t mk_cmd(int fwd, int side, int turn, logic [ModeW-1:0] mode,
                                          int slow, int ofs);
    chassis_cmd_t c;
    c.fwd = SpeedW'(fwd);
    c.side = SpeedW'(side);
    c.turn = SpeedW'(turn);
    c.mode = mode;
    c.slow = 1'(slow);
    c.ofs = SpeedW'(ofs);
    return c;
  endfunction

  // Mostly moderate commands that exercise the limiter, some full-range noise.
  function automatic chassis_cmd_t random_cmd();
    chassis_cmd_t c;
    if ($urandom_range(0, 9) < 6) begin
      c.fwd = SpeedW'(int'($urandom_range(0, 16383)) - 8192);
      c.side = SpeedW'(int'($urandom_range(0, 16383)) - 8192);
      c.turn = SpeedW'(int'($urandom_range(0, 32767)) - 16384);
      c.ofs = SpeedW'(int'($urandom_range(0, 400)) - 200);
    end else begin
      c.fwd = SpeedW'($urandom);
      c.side = SpeedW'($urandom);
      c.turn = SpeedW'($urandom);
      c.ofs = SpeedW'($urandom);
    end
    if ($urandom_range(0, 9) == 0) c.mode = ModeW'($urandom_range(5, 7));
    else c.mode = ModeW'($urandom_range(0, 4));
    c.slow = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Sends one command request and records its expected result on acceptance.
  task automatic send_cmd(chassis_cmd_t c);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid           <= 1'b1;
    cmd_bus.forward_speed   <= c.fwd;
    cmd_bus.sideways_speed  <= c.side;
    cmd_bus.turn_rate       <= c.turn;
    cmd_bus.drive_mode      <= c.mode;
    cmd_bus.slow_mode       <= c.slow;
    cmd_bus.yaw_rate_offset <= c.ofs;
    do @(posedge clk_i); while (!cmd_bus.ready);
    expected_wheels.push_back(predict_wheels(c, cfg_now));
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_wheels.size() != 0) @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_reg(cfg_reg_e idx, logic [ApbDataW-1:0] val);
    logic [ApbDataW-1:0] mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mask = (idx == RegMaxSpeed) ? ApbDataW'((1 << LimW) - 1) : ApbDataW'((1 << GainW) - 1);
    check_field("prdata", val & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegFrontGain: cfg_now.front_gain = val[GainW-1:0];
      RegRearGain:  cfg_now.rear_gain = val[GainW-1:0];
      default:      cfg_now.max_speed = val[LimW-1:0];
    endcase
  endtask

  task automatic apply_config(logic signed [GainW-1:0] front, logic signed [GainW-1:0] rear,
                              logic [LimW-1:0] max_speed);
    write_reg(RegFrontGain, ApbDataW'(front));
    write_reg(RegRearGain, ApbDataW'(rear));
    write_reg(RegMaxSpeed, ApbDataW'(max_speed));
  endtask

  // Random commands with an occasional pause until the pipeline is empty.
  task automatic run_random(int count);
    int until_pause;
    until_pause = $urandom_range(30, 80);
    for (int n = 0; n < count; n++) begin
      send_cmd(random_cmd());
      until_pause--;
      if (until_pause == 0) begin
        drain_results();
        until_pause = $urandom_range(30, 80);
      end
    end
    drain_results();
  endtask

  // Field extremes and every mode code at the reset register values.
  task automatic test_directed_extremes();
    send_cmd(mk_cmd(0, 0, 0, ModeFollowGimbal, 0, 0));
    send_cmd(mk_cmd(32767, 0, 0, ModeNoMove, 0, 0));
    send_cmd(mk_cmd(-32768, -32768, 0, ModeFollowGimbal, 0, 0));
    send_cmd(mk_cmd(0, 32767, 32767, ModeSpin, 1, 32767));
    send_cmd(mk_cmd(0, 0, -32768, ModeNoFollow, 1, -32768));
    send_cmd(mk_cmd(0, 0, 0, ModeZeroForce, 0, 32767));
    send_cmd(mk_cmd(-32768, 32767, -32768, ModeZeroForce, 1, -32768));
    send_cmd(mk_cmd(0, 0, 0, ModeFollowGimbal, 0, 32767));
    // Small commands that need no limiting.
    send_cmd(mk_cmd(100, 50, 0, ModeNoMove, 0, 0));
    for (int m = 0; m < 8; m++) begin
      for (int s = 0; s < 2; s++) begin
        send_cmd(mk_cmd(3000, -1200, 2500, ModeW'(m), s, 30));
      end
    end
    drain_results();
  endtask

  // A zero speed limit forces every nonzero wheel set to zero, except in zero-force mode.
  task automatic test_zero_limit();
    apply_config(FrontGainRst, RearGainRst, '0);
    send_cmd(mk_cmd(0, 0, 0, ModeFollowGimbal, 0, 0));
    send_cmd(mk_cmd(1, 0, 0, ModeNoMove, 0, 0));
    send_cmd(mk_cmd(-5000, 2000, 100, ModeNoFollow, 1, 0));
    send_cmd(mk_cmd(3000, 0, 0, ModeZeroForce, 0, 10));
    send_cmd(mk_cmd(0, 0, 4000, ModeSpin, 0, 0));
    run_random(40);
  endtask

  // Random commands across several gain and limit settings.
  task automatic test_gain_sweep();
    apply_config(16'sh7FFF, -16'sh8000, 15'h7FFF);
    run_random(160);
    apply_config(-16'sh8000, 16'sh7FFF, 15'd1);
    run_random(160);
    apply_config('0, '0, 15'd8192);
    run_random(160);
    apply_config(FrontGainRst, RearGainRst, MaxSpeedRst);
    run_random(160);
    for (int p = 0; p < 2; p++) begin
      apply_config(GainW'($urandom), GainW'($urandom), LimW'($urandom));
      run_random(160);
    end
  endtask

  // Back-to-back requests with no idling on either side.
  task automatic test_back_to_back();
    apply_config(GainW'($urandom), GainW'($urandom), LimW'($urandom_range(2048, 20000)));
    idle_on = 1'b0;
    run_random(120);
  endtask

  initial begin
    rst_ni                  <= 1'b0;
    cmd_bus.valid           <= 1'b0;
    cmd_bus.forward_speed   <= '0;
    cmd_bus.sideways_speed  <= '0;
    cmd_bus.turn_rate       <= '0;
    cmd_bus.drive_mode      <= ModeZeroForce;
    cmd_bus.slow_mode       <= 1'b0;
    cmd_bus.yaw_rate_offset <= '0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    cfg_now.front_gain = FrontGainRst;
    cfg_now.rear_gain  = RearGainRst;
    cfg_now.max_speed  = MaxSpeedRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_zero_limit();
    test_gain_sweep();
    test_back_to_back();

    // Let the pipeline settle so that any stray result shows up.
    drain_results();
    repeat (30) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
